// ===== hdl/crt_pkg.sv =====
// ----------------------------------------------------------------------------
// crt_pkg: shared types and codes of the claim reference-count table
// Holds the mode and status codes, the sequencer states and the structs
// that travel between the table sequencer and the top level.
// ----------------------------------------------------------------------------
package crt_pkg;

	// Fixed widths of the channel fields.
	localparam int MODE_BITS      = 3;
	localparam int TAG_IN_BITS    = 16;
	localparam int COUNT_OUT_BITS = 8;

	// Modes of an input transaction. Codes above MODE_QUERY act as a query.
	localparam logic [MODE_BITS-1:0] MODE_CLAIM              = 3'd0;
	localparam logic [MODE_BITS-1:0] MODE_RELEASE            = 3'd1;
	localparam logic [MODE_BITS-1:0] MODE_RELEASE_TAG        = 3'd2;
	localparam logic [MODE_BITS-1:0] MODE_RELEASE_EVERYTHING = 3'd3;
	localparam logic [MODE_BITS-1:0] MODE_QUERY              = 3'd4;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BUSY      = 3'd1,
		ST_FULL      = 3'd2,
		ST_MISSING   = 3'd3,
		ST_SATURATED = 3'd4
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_ACT,
		S_SHIFT,
		S_DONE
	} seq_state_t;

	// One request as taken from the input channel.
	typedef struct packed {
		logic [MODE_BITS-1:0]   mode;
		logic [TAG_IN_BITS-1:0] context_tag;
	} request_t;

	// One finished result.
	typedef struct packed {
		status_t                   status;
		logic                      is_first;
		logic                      is_claimed;
		logic                      any_claimed;
		logic [COUNT_OUT_BITS-1:0] claim_count;
	} result_t;

endpackage

// ===== hdl/crt_if.sv =====
// ----------------------------------------------------------------------------
// crt_if: request and result channels
// Valid/ready channels; a transaction moves on a rising edge with both high.
// ----------------------------------------------------------------------------
interface crt_in_if import crt_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [MODE_BITS-1:0]   mode;
	logic [TAG_IN_BITS-1:0] context_tag;

	modport source (output valid, output mode, output context_tag, input ready);
	modport sink   (input valid, input mode, input context_tag, output ready);
endinterface

interface crt_out_if import crt_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [2:0]                status;
	logic                      is_first;
	logic                      is_claimed;
	logic                      any_claimed;
	logic [COUNT_OUT_BITS-1:0] claim_count;

	modport source (output valid, output status, output is_first, output is_claimed,
		output any_claimed, output claim_count, input ready);
	modport sink   (input valid, input status, input is_first, input is_claimed,
		input any_claimed, input claim_count, output ready);
endinterface

// ===== hdl/crt_ram.sv =====
// ----------------------------------------------------------------------------
// crt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module crt_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== hdl/crt_seq.sv =====
// ----------------------------------------------------------------------------
// crt_seq: table sequencer
// Scans the entry RAM one slot a cycle with a shared tag comparator, applies
// the requested mode and compacts the table by a shift sweep on removal.
// ----------------------------------------------------------------------------
module crt_seq import crt_pkg::*; #(
	parameter int MAX_ENTRIES = 8,
	parameter int TAG_BITS    = 16,
	parameter int COUNT_BITS  = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     claim_enable,
	input  logic     in_valid,
	output logic     in_ready,
	input  request_t req,
	output logic     done,
	input  logic     done_ack,
	output result_t  result
);

	localparam int OW = $clog2(MAX_ENTRIES + 1);
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int DW = TAG_BITS + COUNT_BITS;

	seq_state_t            state_q, state_d;
	logic [MODE_BITS-1:0]  mode_q;
	logic [TAG_BITS-1:0]   tag_q;
	logic [OW-1:0]         occ_q;
	logic [OW-1:0]         idx_q;
	logic [AW-1:0]         k_q;
	logic                  found_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  rd_vld_s1;
	logic [AW-1:0]         rd_idx_s1;
	result_t               res_q;

	logic [AW-1:0]         ram_rd_addr;
	logic [DW-1:0]         ram_rd_data;
	logic                  ram_we;
	logic [AW-1:0]         ram_wr_addr;
	logic [DW-1:0]         ram_wr_data;
	logic [TAG_BITS-1:0]   rd_tag;
	logic [COUNT_BITS-1:0] rd_cnt;

	logic hit;
	logic more;
	logic issue;
	logic accept;

	status_t               act_status;
	logic                  act_first;
	logic                  act_remove;
	logic                  act_upd;
	logic                  act_ins;
	logic                  act_any;
	logic [COUNT_BITS-1:0] act_new_cnt;
	logic [COUNT_BITS-1:0] act_res_cnt;

	crt_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_ENTRIES)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Shared comparator on the entry coming back from the RAM.
	assign rd_tag = ram_rd_data[DW-1:COUNT_BITS];
	assign rd_cnt = ram_rd_data[COUNT_BITS-1:0];
	assign hit    = rd_vld_s1 && (rd_tag == tag_q);
	assign more   = idx_q < occ_q;
	assign accept = in_valid && in_ready;

	// Decision of the action step from the scan outcome.
	always_comb begin
		act_status  = ST_OK;
		act_first   = 1'b0;
		act_remove  = 1'b0;
		act_upd     = 1'b0;
		act_ins     = 1'b0;
		act_new_cnt = cnt_q;
		act_res_cnt = found_q ? cnt_q : '0;
		case (mode_q)
			MODE_CLAIM: begin
				if (!claim_enable) begin
					act_status = ST_BUSY;
				end else if (found_q) begin
					if (cnt_q == {COUNT_BITS{1'b1}}) begin
						act_status = ST_SATURATED;
					end else begin
						act_upd     = 1'b1;
						act_new_cnt = cnt_q + COUNT_BITS'(1);
						act_res_cnt = act_new_cnt;
					end
				end else if (occ_q == OW'(MAX_ENTRIES)) begin
					act_status = ST_FULL;
				end else begin
					act_ins     = 1'b1;
					act_first   = (occ_q == '0);
					act_new_cnt = COUNT_BITS'(1);
					act_res_cnt = act_new_cnt;
				end
			end
			MODE_RELEASE: begin
				if (found_q) begin
					act_new_cnt = cnt_q - COUNT_BITS'(1);
					if (cnt_q == COUNT_BITS'(1)) begin
						act_remove  = 1'b1;
						act_res_cnt = '0;
					end else begin
						act_upd     = 1'b1;
						act_res_cnt = act_new_cnt;
					end
				end else begin
					act_status  = ST_MISSING;
				end
			end
			MODE_RELEASE_TAG: begin
				act_remove  = found_q;
				act_res_cnt = '0;
			end
			default: begin
			end
		endcase
		act_any = act_ins || (act_remove ? (occ_q > OW'(1)) : (occ_q != '0));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (req.mode == MODE_RELEASE_EVERYTHING) ? S_DONE : S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit || !more) begin
					state_d = S_ACT;
				end
			end
			S_ACT: begin
				state_d = act_remove ? S_SHIFT : S_DONE;
			end
			S_SHIFT: begin
				if (!more && !rd_vld_s1) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (done_ack) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs and RAM control.
	always_comb begin
		in_ready    = 1'b0;
		done        = 1'b0;
		issue       = 1'b0;
		ram_rd_addr = idx_q[AW-1:0];
		ram_we      = 1'b0;
		ram_wr_addr = k_q;
		ram_wr_data = {tag_q, act_new_cnt};
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_SCAN: begin
				issue = !hit && more;
			end
			S_ACT: begin
				ram_we      = act_upd || act_ins;
				ram_wr_addr = act_ins ? occ_q[AW-1:0] : k_q;
			end
			S_SHIFT: begin
				issue       = more;
				ram_we      = rd_vld_s1;
				ram_wr_addr = rd_idx_s1 - AW'(1);
				ram_wr_data = ram_rd_data;
			end
			S_DONE: begin
				done = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign result = res_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			occ_q     <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (accept) begin
				idx_q <= '0;
				if (req.mode == MODE_RELEASE_EVERYTHING) begin
					occ_q <= '0;
				end
			end else if (issue) begin
				idx_q <= idx_q + OW'(1);
			end else if (state_q == S_ACT) begin
				idx_q <= OW'(k_q) + OW'(1);
				if (act_ins) begin
					occ_q <= occ_q + OW'(1);
				end
			end
			if (state_q == S_SHIFT && !more && !rd_vld_s1) begin
				occ_q <= occ_q - OW'(1);
			end
		end
	end

	// Request, scan outcome and result payload.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[AW-1:0];
		if (accept) begin
			mode_q  <= req.mode;
			tag_q   <= TAG_BITS'(req.context_tag);
			found_q <= 1'b0;
			res_q   <= '{status: ST_OK, is_first: 1'b0, is_claimed: 1'b0,
				any_claimed: 1'b0, claim_count: '0};
		end
		if (state_q == S_SCAN && hit) begin
			found_q <= 1'b1;
			k_q     <= rd_idx_s1;
			cnt_q   <= rd_cnt;
		end
		if (state_q == S_ACT) begin
			res_q.status      <= act_status;
			res_q.is_first    <= act_first;
			res_q.is_claimed  <= (act_res_cnt != '0);
			res_q.any_claimed <= act_any;
			res_q.claim_count <= COUNT_OUT_BITS'(act_res_cnt);
		end
	end

	// The table never holds more entries than it has slots.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(MAX_ENTRIES))
		else $error("occupancy above table size");

	// A shift write always lands inside the occupied region.
	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && ram_we) |-> (OW'(ram_wr_addr) + OW'(1) < occ_q))
		else $error("shift write outside the occupied slots");

	// Releasing everything empties the table at once.
	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.mode == MODE_RELEASE_EVERYTHING) |=> (occ_q == '0))
		else $error("table not empty after release of everything");

	// Read data is only pending while a sweep is running.
	a_rd_pending: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_SCAN || state_q == S_SHIFT))
		else $error("pending read outside scan or shift");

endmodule

// ===== hdl/claim_refcount_table_core.sv =====
// ----------------------------------------------------------------------------
// claim_refcount_table_core: claim reference-count table
// Table of claimant tags with claim counts, kept compact in first-claim
// order, with a claim-enable register and valid/ready channels.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time. A request is accepted, then
// the entry RAM is scanned one slot per cycle through a single registered
// read port, ending at the matching tag or after the last occupied slot.
// The action state then applies the mode. Removing an entry adds a sweep
// that moves every higher entry down one slot. The done state then hands
// the result to an output register, and the next request is accepted while
// it waits there. A release of everything skips the scan and goes straight
// to the hand-off. While the output register still holds an unaccepted
// result, the block waits in its hand-off state.
// ----------------------------------------------------------------------------
module claim_refcount_table_core import crt_pkg::*; #(
	parameter int MAX_ENTRIES = 8,
	parameter int TAG_BITS    = 16,
	parameter int COUNT_BITS  = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	crt_in_if.sink           in_ch,
	crt_out_if.source        out_ch
);

	logic     claim_enable_q;
	logic     done;
	logic     done_ack;
	logic     in_ready;
	request_t req;
	result_t  result;
	logic     out_vld_q;
	result_t  out_res_q;

	// Claim-enable register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			claim_enable_q <= 1'b0;
		end else if (cfg_we) begin
			claim_enable_q <= cfg_wdata;
		end
	end

	assign req.mode        = in_ch.mode;
	assign req.context_tag = in_ch.context_tag;
	assign in_ch.ready     = in_ready;

	crt_seq #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.TAG_BITS    (TAG_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.claim_enable (claim_enable_q),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ready),
		.req          (req),
		.done         (done),
		.done_ack     (done_ack),
		.result       (result)
	);

	// Output register: takes a finished result whenever its slot is free.
	assign done_ack = done && (!out_vld_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (done_ack) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_ack) begin
			out_res_q <= result;
		end
	end

	assign out_ch.valid       = out_vld_q;
	assign out_ch.status      = out_res_q.status;
	assign out_ch.is_first    = out_res_q.is_first;
	assign out_ch.is_claimed  = out_res_q.is_claimed;
	assign out_ch.any_claimed = out_res_q.any_claimed;
	assign out_ch.claim_count = out_res_q.claim_count;

endmodule
